FILE: rtl/lcdf_pkg.sv
package lcdf_pkg;

    localparam int FRAME_BITS = 9;
    localparam int BIT_CNT_W  = 4;

    localparam logic [BIT_CNT_W-1:0] BIT_FIRST = BIT_CNT_W'(0);
    localparam logic [BIT_CNT_W-1:0] BIT_LAST  = BIT_CNT_W'(FRAME_BITS - 1);

    localparam logic [7:0] PAGE_CMD    = 8'hB0;
    localparam logic [7:0] LOW_NIBBLE  = 8'h0F;
    localparam logic [7:0] HIGH_COLCMD = 8'h10;
    localparam logic [2:0] HIGH_MASK   = 3'h7;

    typedef enum logic [1:0] {
        OP_DATA       = 2'd0,
        OP_CMD        = 2'd1,
        OP_GOTO_PIXEL = 2'd2,
        OP_GOTO_CELL  = 2'd3
    } opcode_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_value;
        logic       invert;
        logic [6:0] column;
        logic [3:0] row;
    } in_item_t;

    typedef struct packed {
        logic sda_bit;
        logic is_type_bit;
        logic frame_end;
        logic last;
    } out_item_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] payload;
        logic       last;
    } frame_t;

endpackage

FILE: rtl/lcdf_in_if.sv
interface lcdf_in_if;
    logic               valid;
    logic               ready;
    lcdf_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/lcdf_out_if.sv
interface lcdf_out_if;
    logic                valid;
    logic                ready;
    lcdf_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/lcd_nine_bit_serial_framer.sv
// Channel  Dir  Payload
// item     in   opcode, byte_value, invert, column, row
// result   out  sda_bit, is_type_bit, frame_end, last (one wire bit each)
//
// The back end shifts out one wire bit per cycle while it holds a frame and
// result does not stall; data or command is one frame, a goto three.
// The front end splits a transaction into frames, registers them, and feeds
// a frame queue of QUEUE_DEPTH entries; it takes the next transaction while
// earlier frames are still shifting. Stalls on result hold the output register.
// rst_n clears all control state asynchronously; no clearing pass.
module lcd_nine_bit_serial_framer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    lcdf_in_if.sink    item,
    lcdf_out_if.source result
);

    logic             q_wr_valid;
    logic             q_wr_ready;
    lcdf_pkg::frame_t q_wr_frame;
    logic             q_rd_valid;
    logic             q_rd_ready;
    lcdf_pkg::frame_t q_rd_frame;

    lcdf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .push_valid (q_wr_valid),
        .push_ready (q_wr_ready),
        .push_frame (q_wr_frame)
    );

    lcdf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_frame (q_wr_frame),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_frame (q_rd_frame)
    );

    lcdf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (q_rd_valid),
        .pop_ready (q_rd_ready),
        .pop_frame (q_rd_frame),
        .result    (result)
    );

endmodule

FILE: rtl/lcdf_front.sv
module lcdf_front (
    input  logic             clk,
    input  logic             rst_n,
    lcdf_in_if.sink          item,
    output logic             push_valid,
    input  logic             push_ready,
    output lcdf_pkg::frame_t push_frame
);

    lcdf_pkg::frame_t frm_reg [3];
    lcdf_pkg::frame_t frm_next [3];
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;
    lcdf_pkg::frame_t cls [3];
    logic [1:0]       cls_cnt;
    logic [7:0]       col_x;
    logic [7:0]       col6;
    logic             push;
    logic             take;

    assign push_valid = (cnt_reg != 2'd0);
    assign push_frame = frm_reg[0];
    assign push       = push_valid && push_ready;
    assign item.ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && push_ready);
    assign take       = item.valid && item.ready;

    assign col6 = {item.data.column[5:0], 2'b00} + {item.data.column, 1'b0};

    always_comb
    begin
        col_x   = {1'b0, item.data.column};
        cls_cnt = 2'd1;
        for (int i = 0; i < 3; i++)
        begin
            cls[i] = '0;
        end
        unique case (lcdf_pkg::opcode_t'(item.data.opcode)) inside
            lcdf_pkg::OP_DATA:
            begin
                cls[0].is_data = 1'b1;
                cls[0].payload = item.data.invert ? ~item.data.byte_value
                                                  : item.data.byte_value;
                cls[0].last    = 1'b1;
            end
            lcdf_pkg::OP_CMD:
            begin
                cls[0].payload = item.data.byte_value;
                cls[0].last    = 1'b1;
            end
            lcdf_pkg::OP_GOTO_PIXEL, lcdf_pkg::OP_GOTO_CELL:
            begin
                if (lcdf_pkg::opcode_t'(item.data.opcode) == lcdf_pkg::OP_GOTO_CELL)
                begin
                    col_x = col6;
                end
                cls_cnt        = 2'd3;
                cls[0].payload = lcdf_pkg::PAGE_CMD | {4'h0, item.data.row};
                cls[1].payload = col_x & lcdf_pkg::LOW_NIBBLE;
                cls[2].payload = lcdf_pkg::HIGH_COLCMD
                               | {5'h00, col_x[6:4] & lcdf_pkg::HIGH_MASK};
                cls[2].last    = 1'b1;
            end
            default:
            begin
                cls_cnt = 2'd1;
            end
        endcase
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        frm_next[0] = frm_reg[0];
        frm_next[1] = frm_reg[1];
        frm_next[2] = frm_reg[2];
        if (take)
        begin
            cnt_next    = cls_cnt;
            frm_next[0] = cls[0];
            frm_next[1] = cls[1];
            frm_next[2] = cls[2];
        end
        else if (push)
        begin
            cnt_next    = cnt_reg - 2'd1;
            frm_next[0] = frm_reg[1];
            frm_next[1] = frm_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frm_reg[0] <= frm_next[0];
        frm_reg[1] <= frm_next[1];
        frm_reg[2] <= frm_next[2];
    end

endmodule

FILE: rtl/lcdf_queue.sv
module lcdf_queue #(
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  lcdf_pkg::frame_t wr_frame,
    output logic             rd_valid,
    input  logic             rd_ready,
    output lcdf_pkg::frame_t rd_frame
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lcdf_pkg::frame_t mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             wr;
    logic             rd;

    assign wr_ready = (fill_reg != CNT_W'(DEPTH));
    assign rd_valid = (fill_reg != CNT_W'(0));
    assign rd_frame = mem[rd_ptr_reg];
    assign wr       = wr_valid && wr_ready;
    assign rd       = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0)
                                                            : wr_ptr_reg + PTR_W'(1);
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0)
                                                            : rd_ptr_reg + PTR_W'(1);
        end
        if (wr && !rd)
        begin
            fill_next = fill_reg + CNT_W'(1);
        end
        else if (rd && !wr)
        begin
            fill_next = fill_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_ptr_reg] <= wr_frame;
        end
    end

endmodule

FILE: rtl/lcdf_back.sv
module lcdf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pop_valid,
    output logic             pop_ready,
    input  lcdf_pkg::frame_t pop_frame,
    lcdf_out_if.source       result
);

    logic                          active_reg;
    logic                          active_next;
    logic [lcdf_pkg::FRAME_BITS-1:0] shift_reg;
    logic [lcdf_pkg::FRAME_BITS-1:0] shift_next;
    logic [lcdf_pkg::BIT_CNT_W-1:0]  bit_reg;
    logic [lcdf_pkg::BIT_CNT_W-1:0]  bit_next;
    logic                          last_reg;
    logic                          last_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    lcdf_pkg::out_item_t           out_data_reg;
    lcdf_pkg::out_item_t           out_data_next;
    logic                          slot_free;
    logic                          emit;
    logic                          done;
    logic                          pop;

    assign slot_free = !out_valid_reg || result.ready;
    assign emit      = active_reg && slot_free;
    assign done      = emit && (bit_reg == lcdf_pkg::BIT_LAST);
    assign pop_ready = !active_reg || done;
    assign pop       = pop_valid && pop_ready;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_comb
    begin
        active_next    = active_reg;
        shift_next     = shift_reg;
        bit_next       = bit_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next            = 1'b1;
            out_data_next.sda_bit     = shift_reg[lcdf_pkg::FRAME_BITS-1];
            out_data_next.is_type_bit = (bit_reg == lcdf_pkg::BIT_FIRST);
            out_data_next.frame_end   = (bit_reg == lcdf_pkg::BIT_LAST);
            out_data_next.last        = last_reg && (bit_reg == lcdf_pkg::BIT_LAST);
            shift_next                = {shift_reg[lcdf_pkg::FRAME_BITS-2:0], 1'b0};
            bit_next                  = bit_reg + lcdf_pkg::BIT_CNT_W'(1);
        end
        if (pop)
        begin
            active_next = 1'b1;
            shift_next  = {pop_frame.is_data, pop_frame.payload};
            bit_next    = lcdf_pkg::BIT_FIRST;
            last_next   = pop_frame.last;
        end
        else if (done)
        begin
            active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        bit_reg      <= bit_next;
        last_reg     <= last_next;
        out_data_reg <= out_data_next;
    end

endmodule

FILE: rtl/lcdf_checker.sv
module lcdf_checker (
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic sda_bit,
    input logic is_type_bit,
    input logic frame_end,
    input logic last
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({sda_bit, is_type_bit, frame_end, last}))
        else $error("result changed while stalled");

    a_type_not_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_type_bit && frame_end))
        else $error("flag bit marked as frame end");

    a_last_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> frame_end)
        else $error("last outside frame end");

    a_no_early_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !frame_end |=> !(out_valid && is_type_bit))
        else $error("new frame started mid frame");

endmodule

bind lcd_nine_bit_serial_framer lcdf_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .sda_bit     (result.data.sda_bit),
    .is_type_bit (result.data.is_type_bit),
    .frame_end   (result.data.frame_end),
    .last        (result.data.last)
);

FILE: bench/lcd_nine_bit_serial_framer_tb.sv
module lcd_nine_bit_serial_framer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int STEADY_ITEMS = 30;
    localparam int HOLD_ITEMS   = 20;
    localparam int RANDOM_ITEMS = 92;

    // Directed row: typed_bytes holds up to three frame payloads, first frame in
    // the top byte; n_typed of zero leaves the row to the frame predictor.
    typedef struct packed {
        lcdf_pkg::opcode_t op;
        logic [7:0]        byte_value;
        logic              inv;
        logic [6:0]        col;
        logic [3:0]        pg_row;
        logic [1:0]        n_typed;
        logic [23:0]       typed_bytes;
    } dir_row_t;

    localparam int DIR_ROWS = 18;

    dir_row_t dir_table [DIR_ROWS] = '{
        '{lcdf_pkg::OP_DATA,       8'h00, 1'b0, 7'h00, 4'h0, 2'd1, 24'h00_0000},
        '{lcdf_pkg::OP_DATA,       8'hFF, 1'b0, 7'h7F, 4'hF, 2'd1, 24'hFF_0000},
        '{lcdf_pkg::OP_DATA,       8'h00, 1'b1, 7'h00, 4'h0, 2'd1, 24'hFF_0000},
        '{lcdf_pkg::OP_DATA,       8'hFF, 1'b1, 7'h7F, 4'hF, 2'd1, 24'h00_0000},
        '{lcdf_pkg::OP_DATA,       8'hA5, 1'b1, 7'h55, 4'hA, 2'd1, 24'h5A_0000},
        '{lcdf_pkg::OP_DATA,       8'h3C, 1'b0, 7'h2A, 4'h5, 2'd0, 24'h00_0000},
        '{lcdf_pkg::OP_CMD,        8'h00, 1'b0, 7'h00, 4'h0, 2'd1, 24'h00_0000},
        '{lcdf_pkg::OP_CMD,        8'hFF, 1'b1, 7'h7F, 4'hF, 2'd1, 24'hFF_0000},
        '{lcdf_pkg::OP_CMD,        8'h81, 1'b1, 7'h33, 4'h6, 2'd0, 24'h00_0000},
        '{lcdf_pkg::OP_GOTO_PIXEL, 8'h00, 1'b0, 7'h00, 4'h0, 2'd3, 24'hB0_00_10},
        '{lcdf_pkg::OP_GOTO_PIXEL, 8'hFF, 1'b1, 7'h7F, 4'hF, 2'd3, 24'hBF_0F_17},
        '{lcdf_pkg::OP_GOTO_PIXEL, 8'h5A, 1'b1, 7'h2A, 4'h5, 2'd0, 24'h00_0000},
        '{lcdf_pkg::OP_GOTO_CELL,  8'h00, 1'b0, 7'h00, 4'h0, 2'd3, 24'hB0_00_10},
        '{lcdf_pkg::OP_GOTO_CELL,  8'hA5, 1'b1, 7'd42, 4'h3, 2'd3, 24'hB3_0C_17},
        '{lcdf_pkg::OP_GOTO_CELL,  8'h00, 1'b0, 7'd43, 4'h9, 2'd3, 24'hB9_02_10},
        '{lcdf_pkg::OP_GOTO_CELL,  8'hFF, 1'b1, 7'h7F, 4'hF, 2'd3, 24'hBF_0A_17},
        '{lcdf_pkg::OP_GOTO_CELL,  8'h3C, 1'b0, 7'd21, 4'h6, 2'd0, 24'h00_0000},
        '{lcdf_pkg::OP_GOTO_PIXEL, 8'h00, 1'b0, 7'h70, 4'hC, 2'd0, 24'h00_0000}
    };

    logic clk;
    logic rst_n;

    lcdf_in_if  item_ch ();
    lcdf_out_if result_ch ();

    lcd_nine_bit_serial_framer i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    lcdf_pkg::out_item_t wire_bits_q [$];
    int unsigned         fail_cnt;
    int unsigned         bits_checked;
    int unsigned         long_holds;
    int unsigned         op_count [4];
    int unsigned         cycle_cnt;
    bit                  tx_steady;
    bit                  rx_steady;
    bit                  hold_req;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void push_frame_bits(input logic is_data, input logic [7:0] payload,
                                            input logic closing);
        lcdf_pkg::out_item_t b;
        for (int k = 0; k < lcdf_pkg::FRAME_BITS; k++)
        begin
            b.sda_bit     = (k == 0) ? is_data : payload[8 - k];
            b.is_type_bit = (k == 0);
            b.frame_end   = (k == lcdf_pkg::FRAME_BITS - 1);
            b.last        = closing && (k == lcdf_pkg::FRAME_BITS - 1);
            wire_bits_q.push_back(b);
        end
    endfunction

    function automatic void predict_wire_bits(input lcdf_pkg::in_item_t req);
        logic [7:0] x;
        case (lcdf_pkg::opcode_t'(req.opcode))
            lcdf_pkg::OP_DATA:
                push_frame_bits(1'b1, req.invert ? ~req.byte_value : req.byte_value, 1'b1);
            lcdf_pkg::OP_CMD:
                push_frame_bits(1'b0, req.byte_value, 1'b1);
            default:
            begin
                x = {1'b0, req.column};
                if (lcdf_pkg::opcode_t'(req.opcode) == lcdf_pkg::OP_GOTO_CELL)
                    x = 8'(req.column * 6);
                push_frame_bits(1'b0, lcdf_pkg::PAGE_CMD | {4'h0, req.row}, 1'b0);
                push_frame_bits(1'b0, x & lcdf_pkg::LOW_NIBBLE, 1'b0);
                push_frame_bits(1'b0, lcdf_pkg::HIGH_COLCMD
                                      | {5'h00, x[6:4] & lcdf_pkg::HIGH_MASK}, 1'b1);
            end
        endcase
    endfunction

    function automatic lcdf_pkg::in_item_t random_request();
        lcdf_pkg::in_item_t req;
        req.opcode     = 2'($urandom_range(0, 3));
        req.byte_value = 8'($urandom_range(0, 255));
        req.invert     = 1'($urandom_range(0, 1));
        req.column     = 7'($urandom_range(0, 127));
        req.row        = 4'($urandom_range(0, 15));
        return req;
    endfunction

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (tx_steady || roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Offers one transaction; returns at the edge where it was taken.
    task automatic offer(input lcdf_pkg::in_item_t req, input logic [1:0] n_typed,
                         input logic [23:0] typed_bytes);
        int gap;
        bit took;
        gap = gap_len();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= req;
        do
        begin
            @(negedge clk);
            took = item_ch.ready;
            @(posedge clk);
        end
        while (!took);
        op_count[req.opcode]++;
        if (n_typed == 2'd0)
            predict_wire_bits(req);
        else
            for (int i = 0; i < n_typed; i++)
                push_frame_bits(lcdf_pkg::opcode_t'(req.opcode) == lcdf_pkg::OP_DATA,
                                typed_bytes[23 - 8 * i -: 8], i == n_typed - 1);
    endtask

    task automatic wait_drained();
        while (wire_bits_q.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: checks each wire bit and decides ready for the next edge.
    initial
    begin
        lcdf_pkg::out_item_t want;
        lcdf_pkg::out_item_t got;
        int                  stall_left;
        int                  roll;
        bit                  seen;
        stall_left = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            seen = rst_n && result_ch.valid && result_ch.ready;
            got  = result_ch.data;
            @(posedge clk);
            if (seen)
            begin
                if (wire_bits_q.size() == 0)
                begin
                    $error("wire bit with nothing expected: %b", got);
                    fail_cnt++;
                end
                else
                begin
                    want = wire_bits_q.pop_front();
                    bits_checked++;
                    if (got.sda_bit !== want.sda_bit)
                    begin
                        $error("sda_bit: expected %0b, got %0b", want.sda_bit, got.sda_bit);
                        fail_cnt++;
                    end
                    if (got.is_type_bit !== want.is_type_bit)
                    begin
                        $error("is_type_bit: expected %0b, got %0b",
                               want.is_type_bit, got.is_type_bit);
                        fail_cnt++;
                    end
                    if (got.frame_end !== want.frame_end)
                    begin
                        $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
                        fail_cnt++;
                    end
                    if (got.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, got.last);
                        fail_cnt++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = LONG_HOLD;
                long_holds++;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (rx_steady)
                result_ch.ready <= 1'b1;
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                begin
                    stall_left = $urandom_range(10, 40);
                    result_ch.ready <= 1'b0;
                end
                else if (roll < 25)
                begin
                    stall_left = $urandom_range(0, 2);
                    result_ch.ready <= 1'b0;
                end
                else
                    result_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d wire bits outstanding",
                 cycle_cnt, wire_bits_q.size());
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        dir_row_t           row_entry;
        lcdf_pkg::in_item_t req;
        fail_cnt      = 0;
        bits_checked  = 0;
        long_holds    = 0;
        tx_steady     = 1'b0;
        rx_steady     = 1'b0;
        hold_req      = 1'b0;
        for (int i = 0; i < 4; i++)
            op_count[i] = 0;
        rst_n         <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            row_entry      = dir_table[i];
            req.opcode     = row_entry.op;
            req.byte_value = row_entry.byte_value;
            req.invert     = row_entry.inv;
            req.column     = row_entry.col;
            req.row        = row_entry.pg_row;
            offer(req, row_entry.n_typed, row_entry.typed_bytes);
        end

        // back-to-back on both sides
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        for (int i = 0; i < STEADY_ITEMS; i++)
            offer(random_request(), 2'd0, '0);
        rx_steady = 1'b0;

        // receiver holds off while the sender keeps offering, filling the frame queue
        hold_req = 1'b1;
        for (int i = 0; i < HOLD_ITEMS; i++)
            offer(random_request(), 2'd0, '0);
        tx_steady = 1'b0;
        item_ch.valid <= 1'b0;
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++)
            offer(random_request(), 2'd0, '0);
        item_ch.valid <= 1'b0;

        rx_steady = 1'b1;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests: %0d data, %0d command, %0d pixel goto, %0d cell goto",
                 op_count[lcdf_pkg::OP_DATA], op_count[lcdf_pkg::OP_CMD],
                 op_count[lcdf_pkg::OP_GOTO_PIXEL], op_count[lcdf_pkg::OP_GOTO_CELL]);
        $display("%0d wire bits compared, %0d long receiver hold(s), %0d mismatch(es)",
                 bits_checked, long_holds, fail_cnt);
        if (fail_cnt == 0 && wire_bits_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/lcdf_pkg.sv
rtl/lcdf_in_if.sv
rtl/lcdf_out_if.sv
rtl/lcdf_front.sv
rtl/lcdf_queue.sv
rtl/lcdf_back.sv
rtl/lcd_nine_bit_serial_framer.sv
rtl/lcdf_checker.sv
bench/lcd_nine_bit_serial_framer_tb.sv
